[rtl/assert_macros.svh]
// assertion macros used by the rtl top level
// no dependencies; each macro takes the clock and the active-low reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define AST_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// same-cycle implication
`define AST_IMP(lbl, clk, rst_n, ante, cons) \
    `AST_PROP(lbl, clk, rst_n, (ante) |-> (cons))

// next-cycle implication
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    `AST_PROP(lbl, clk, rst_n, (ante) |=> (cons))

`endif

[rtl/ppl_pkg.sv]
// package of the positional pair list: widths, codes and shared types
// no dependencies
package ppl_pkg;

    localparam int PPL_DEPTH       = 32;
    localparam int PPL_KEY_WIDTH   = 32;
    localparam int PPL_VALUE_WIDTH = 32;

    // fixed field widths of the item channels
    localparam int FUNC_W   = 2;
    localparam int IDX_W    = 6;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;

    typedef logic [FUNC_W-1:0]   t_func;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic [IDX_W-1:0]    t_idx;

    localparam t_func FUNC_APPEND = 2'd0;
    localparam t_func FUNC_INSERT = 2'd1;
    localparam t_func FUNC_REMOVE = 2'd2;

    localparam t_status STATUS_OK        = 2'd0;
    localparam t_status STATUS_BAD_POS   = 2'd1;
    localparam t_status STATUS_FULL      = 2'd2;
    localparam t_status STATUS_BAD_RANGE = 2'd3;

    // per-cell load select
    typedef logic [1:0] t_cell_op;
    localparam t_cell_op CELL_HOLD       = 2'd0;
    localparam t_cell_op CELL_LOAD_IN    = 2'd1;
    localparam t_cell_op CELL_FROM_LEFT  = 2'd2;
    localparam t_cell_op CELL_FROM_RIGHT = 2'd3;

    // whole-chain command
    typedef logic [1:0] t_cmd_mode;
    localparam t_cmd_mode CMD_NONE       = 2'd0;
    localparam t_cmd_mode CMD_WRITE      = 2'd1;
    localparam t_cmd_mode CMD_INSERT     = 2'd2;
    localparam t_cmd_mode CMD_SHIFT_DOWN = 2'd3;

    typedef struct packed {
        t_cmd_mode mode;
        t_idx      index;
    } t_chain_cmd;

endpackage

[rtl/ppl_in_if.sv]
// input item channel of the positional pair list
// depends on ppl_pkg
interface ppl_in_if;
    logic              valid;
    logic              ready;
    ppl_pkg::t_func    func;
    ppl_pkg::t_idx     position;
    ppl_pkg::t_idx     remove_count;
    logic [ppl_pkg::DATA_W-1:0] key_in;
    logic [ppl_pkg::DATA_W-1:0] value_in;

    modport source (output valid, func, position, remove_count, key_in, value_in,
                    input ready);
    modport sink   (input valid, func, position, remove_count, key_in, value_in,
                    output ready);
endinterface

[rtl/ppl_out_if.sv]
// result item channel of the positional pair list
// depends on ppl_pkg
interface ppl_out_if;
    logic              valid;
    logic              ready;
    ppl_pkg::t_status  status;
    logic              removed_valid;
    logic [ppl_pkg::DATA_W-1:0] key_out;
    logic [ppl_pkg::DATA_W-1:0] value_out;
    logic              last;
    ppl_pkg::t_idx     occupancy;

    modport source (output valid, status, removed_valid, key_out, value_out, last,
                    occupancy, input ready);
    modport sink   (input valid, status, removed_valid, key_out, value_out, last,
                    occupancy, output ready);
endinterface

[rtl/ppl_cell.sv]
// one storage cell of the pair chain: holds a key and a value
// depends on ppl_pkg for the load select codes
module ppl_cell #(
    parameter int KEY_WIDTH   = ppl_pkg::PPL_KEY_WIDTH,
    parameter int VALUE_WIDTH = ppl_pkg::PPL_VALUE_WIDTH
) (
    input  logic                   i_clk,
    input  ppl_pkg::t_cell_op      i_op,
    input  logic [KEY_WIDTH-1:0]   i_new_key,
    input  logic [VALUE_WIDTH-1:0] i_new_value,
    input  logic [KEY_WIDTH-1:0]   i_left_key,
    input  logic [VALUE_WIDTH-1:0] i_left_value,
    input  logic [KEY_WIDTH-1:0]   i_right_key,
    input  logic [VALUE_WIDTH-1:0] i_right_value,
    output logic [KEY_WIDTH-1:0]   o_key,
    output logic [VALUE_WIDTH-1:0] o_value
);
    logic [KEY_WIDTH-1:0]   r_key,   n_key;
    logic [VALUE_WIDTH-1:0] r_value, n_value;

    always_comb begin
        case (i_op)
            ppl_pkg::CELL_LOAD_IN: begin
                n_key   = i_new_key;
                n_value = i_new_value;
            end
            ppl_pkg::CELL_FROM_LEFT: begin
                n_key   = i_left_key;
                n_value = i_left_value;
            end
            ppl_pkg::CELL_FROM_RIGHT: begin
                n_key   = i_right_key;
                n_value = i_right_value;
            end
            default: begin
                n_key   = r_key;
                n_value = r_value;
            end
        endcase
    end

    // payload only, no reset
    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_value <= n_value;
    end

    assign o_key   = r_key;
    assign o_value = r_value;
endmodule

[rtl/ppl_chain.sv]
// row of pair cells with per-cell load decode and a read port at one position
// depends on ppl_pkg and ppl_cell
module ppl_chain #(
    parameter int DEPTH       = ppl_pkg::PPL_DEPTH,
    parameter int KEY_WIDTH   = ppl_pkg::PPL_KEY_WIDTH,
    parameter int VALUE_WIDTH = ppl_pkg::PPL_VALUE_WIDTH
) (
    input  logic                   i_clk,
    input  ppl_pkg::t_chain_cmd    i_cmd,
    input  logic [KEY_WIDTH-1:0]   i_key,
    input  logic [VALUE_WIDTH-1:0] i_value,
    input  ppl_pkg::t_idx          i_rd_idx,
    output logic [KEY_WIDTH-1:0]   o_rd_key,
    output logic [VALUE_WIDTH-1:0] o_rd_value
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [KEY_WIDTH-1:0]   w_key   [DEPTH];
    logic [VALUE_WIDTH-1:0] w_value [DEPTH];
    ppl_pkg::t_cell_op      w_op    [DEPTH];

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [KEY_WIDTH-1:0]   w_lk, w_rk;
            logic [VALUE_WIDTH-1:0] w_lv, w_rv;

            // chain ends: first cell never loads from the left, last never from the right
            if (g == 0) begin : g_first
                assign w_lk = i_key;
                assign w_lv = i_value;
            end else begin : g_mid_l
                assign w_lk = w_key[g-1];
                assign w_lv = w_value[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign w_rk = w_key[g];
                assign w_rv = w_value[g];
            end else begin : g_mid_r
                assign w_rk = w_key[g+1];
                assign w_rv = w_value[g+1];
            end

            always_comb begin
                w_op[g] = ppl_pkg::CELL_HOLD;
                case (i_cmd.mode)
                    ppl_pkg::CMD_WRITE: begin
                        if (i_cmd.index == ppl_pkg::IDX_W'(g))
                            w_op[g] = ppl_pkg::CELL_LOAD_IN;
                    end
                    ppl_pkg::CMD_INSERT: begin
                        if (i_cmd.index == ppl_pkg::IDX_W'(g))
                            w_op[g] = ppl_pkg::CELL_LOAD_IN;
                        else if (i_cmd.index < ppl_pkg::IDX_W'(g))
                            w_op[g] = ppl_pkg::CELL_FROM_LEFT;
                    end
                    ppl_pkg::CMD_SHIFT_DOWN: begin
                        if ((i_cmd.index <= ppl_pkg::IDX_W'(g)) && (g < DEPTH - 1))
                            w_op[g] = ppl_pkg::CELL_FROM_RIGHT;
                    end
                    default: w_op[g] = ppl_pkg::CELL_HOLD;
                endcase
            end

            ppl_cell #(
                .KEY_WIDTH   (KEY_WIDTH),
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .i_clk         (i_clk),
                .i_op          (w_op[g]),
                .i_new_key     (i_key),
                .i_new_value   (i_value),
                .i_left_key    (w_lk),
                .i_left_value  (w_lv),
                .i_right_key   (w_rk),
                .i_right_value (w_rv),
                .o_key         (w_key[g]),
                .o_value       (w_value[g])
            );
        end
    endgenerate

    assign o_rd_key   = w_key[i_rd_idx[AW-1:0]];
    assign o_rd_value = w_value[i_rd_idx[AW-1:0]];
endmodule

[rtl/positional_pair_list_top.sv]
// top level of the positional pair list: control sequencer, result register, cell chain
// depends on ppl_pkg, ppl_in_if, ppl_out_if, ppl_chain and assert_macros.svh
//
// Ordered list of up to DEPTH (key, value) pairs held in a row of cells. Append,
// insert-at and every rejected or unused operation give one result item each; with
// the sink ready the block takes such an item in every cycle. Insert shifts the
// upper part of the row up by one place as the item is accepted.
// A remove of n entries is accepted and then emits n result items, one a cycle
// while the sink takes them; each step reads the cell at the range start and
// shifts the row above it down one place, so the single read port of the chain
// sets that rate. No new item is taken until the last removed pair has been
// loaded into the result register. There is a single result register: while a
// result waits in it for the sink, no new item is taken, and the input ready
// follows the sink ready in the same cycle.
// Stored pairs have no reset; only entries below the fill count are ever read.
`include "assert_macros.svh"

module positional_pair_list_top #(
    parameter int DEPTH       = ppl_pkg::PPL_DEPTH,
    parameter int KEY_WIDTH   = ppl_pkg::PPL_KEY_WIDTH,
    parameter int VALUE_WIDTH = ppl_pkg::PPL_VALUE_WIDTH
) (
    input logic       i_clk,
    input logic       i_rst_n,
    ppl_in_if.sink    i_in,
    ppl_out_if.source o_out
);
    // fill count must hold DEPTH itself
    localparam int CNT_W = $clog2(DEPTH + 1);
    // range end check width, wide enough for position + remove_count and the count
    localparam int SUM_W = ((CNT_W > ppl_pkg::IDX_W) ? CNT_W : ppl_pkg::IDX_W) + 1;

    // sequencer states
    localparam logic S_IDLE   = 1'b0;
    localparam logic S_REMOVE = 1'b1;

    logic                 r_state, n_state;
    logic [CNT_W-1:0]     r_count, n_count;
    ppl_pkg::t_idx        r_pos,   n_pos;
    ppl_pkg::t_idx        r_left,  n_left;

    // result register
    logic                 r_out_valid, n_out_valid;
    ppl_pkg::t_status     r_status,  n_status;
    logic                 r_rm_valid, n_rm_valid;
    logic [ppl_pkg::DATA_W-1:0] r_key_out, n_key_out;
    logic [ppl_pkg::DATA_W-1:0] r_val_out, n_val_out;
    logic                 r_last, n_last;
    ppl_pkg::t_idx        r_occ,  n_occ;

    logic                 w_slot_free;
    logic                 w_in_fire;
    logic                 w_out_fire;
    logic                 w_load_out;
    logic                 w_full;
    ppl_pkg::t_chain_cmd  w_cmd;
    logic [KEY_WIDTH-1:0]   w_key_in,  w_rd_key;
    logic [VALUE_WIDTH-1:0] w_val_in,  w_rd_val;
    logic [SUM_W-1:0]     w_range_end;

    // result slot is free when empty or being drained this cycle
    assign w_slot_free = !r_out_valid || o_out.ready;
    assign i_in.ready  = (r_state == S_IDLE) && w_slot_free;
    assign w_in_fire   = i_in.valid && i_in.ready;
    assign w_out_fire  = r_out_valid && o_out.ready;

    assign w_full      = (r_count == CNT_W'(DEPTH));
    assign w_key_in    = KEY_WIDTH'(i_in.key_in);
    assign w_val_in    = VALUE_WIDTH'(i_in.value_in);
    assign w_range_end = SUM_W'(i_in.position) + SUM_W'(i_in.remove_count);

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_pos       = r_pos;
        n_left      = r_left;
        w_cmd.mode  = ppl_pkg::CMD_NONE;
        w_cmd.index = r_pos;
        w_load_out  = 1'b0;
        n_status    = ppl_pkg::STATUS_OK;
        n_rm_valid  = 1'b0;
        n_key_out   = '0;
        n_val_out   = '0;
        n_last      = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    w_load_out = 1'b1;
                    case (i_in.func)
                        ppl_pkg::FUNC_APPEND: begin
                            if (w_full) begin
                                n_status = ppl_pkg::STATUS_FULL;
                            end else begin
                                w_cmd.mode  = ppl_pkg::CMD_WRITE;
                                w_cmd.index = ppl_pkg::IDX_W'(r_count);
                                n_count     = r_count + CNT_W'(1);
                            end
                        end
                        ppl_pkg::FUNC_INSERT: begin
                            // position check comes before the full check
                            if (SUM_W'(i_in.position) > SUM_W'(r_count)) begin
                                n_status = ppl_pkg::STATUS_BAD_POS;
                            end else if (w_full) begin
                                n_status = ppl_pkg::STATUS_FULL;
                            end else begin
                                w_cmd.mode  = ppl_pkg::CMD_INSERT;
                                w_cmd.index = i_in.position;
                                n_count     = r_count + CNT_W'(1);
                            end
                        end
                        ppl_pkg::FUNC_REMOVE: begin
                            if ((i_in.remove_count == '0) ||
                                (w_range_end > SUM_W'(r_count))) begin
                                n_status = ppl_pkg::STATUS_BAD_RANGE;
                            end else begin
                                // results come from the remove steps
                                w_load_out = 1'b0;
                                n_state    = S_REMOVE;
                                n_pos      = i_in.position;
                                n_left     = i_in.remove_count;
                                n_count    = r_count - CNT_W'(i_in.remove_count);
                            end
                        end
                        default: n_status = ppl_pkg::STATUS_OK;
                    endcase
                end
            end
            S_REMOVE: begin
                if (w_slot_free) begin
                    // emit the pair at the range start, pull the rest down
                    w_load_out  = 1'b1;
                    w_cmd.mode  = ppl_pkg::CMD_SHIFT_DOWN;
                    w_cmd.index = r_pos;
                    n_rm_valid  = 1'b1;
                    n_key_out   = ppl_pkg::DATA_W'(w_rd_key);
                    n_val_out   = ppl_pkg::DATA_W'(w_rd_val);
                    n_last      = (r_left == ppl_pkg::IDX_W'(1));
                    n_left      = r_left - ppl_pkg::IDX_W'(1);
                    if (r_left == ppl_pkg::IDX_W'(1))
                        n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // occupancy always reports the count after the whole operation
        n_occ = ppl_pkg::IDX_W'(n_count);

        if (w_load_out)
            n_out_valid = 1'b1;
        else if (w_out_fire)
            n_out_valid = 1'b0;
        else
            n_out_valid = r_out_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
        end
    end

    // payload: the range start is loaded every cycle, the result fields only with a new result
    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        if (w_load_out) begin
            r_status   <= n_status;
            r_rm_valid <= n_rm_valid;
            r_key_out  <= n_key_out;
            r_val_out  <= n_val_out;
            r_last     <= n_last;
            r_occ      <= n_occ;
        end
    end

    ppl_chain #(
        .DEPTH       (DEPTH),
        .KEY_WIDTH   (KEY_WIDTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_chain (
        .i_clk      (i_clk),
        .i_cmd      (w_cmd),
        .i_key      (w_key_in),
        .i_value    (w_val_in),
        .i_rd_idx   (r_pos),
        .o_rd_key   (w_rd_key),
        .o_rd_value (w_rd_val)
    );

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_status;
    assign o_out.removed_valid = r_rm_valid;
    assign o_out.key_out       = r_key_out;
    assign o_out.value_out     = r_val_out;
    assign o_out.last          = r_last;
    assign o_out.occupancy     = r_occ;

    // no new item while a removal is still emitting
    `AST_IMP(a_no_accept_in_remove, i_clk, i_rst_n, r_state == S_REMOVE, !i_in.ready)
    // fill count stays within the row
    `AST_PROP(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(DEPTH))
    // a removal in progress always has entries left to emit
    `AST_IMP(a_left_nonzero, i_clk, i_rst_n, r_state == S_REMOVE, r_left != '0)
    // the final removed pair carries last and returns to idle
    `AST_NEXT(a_last_ends_remove, i_clk, i_rst_n,
              (r_state == S_REMOVE) && w_slot_free && (r_left == ppl_pkg::IDX_W'(1)),
              (r_state == S_IDLE) && r_out_valid && r_last)
endmodule

[verif/positional_pair_list_top_tb.sv]
// self-checking bench for positional_pair_list_top: list operations in, replies checked in order
// depends on ppl_pkg, ppl_in_if and ppl_out_if; keeps its own shadow list to predict every reply
`timescale 1ns / 1ps

module positional_pair_list_top_tb;

    // the unused operation code, accepted and answered without any change
    localparam ppl_pkg::t_func FUNC_UNUSED = 2'd3;
    localparam int    CYCLE_LIMIT = 400000;
    // longest removal plus slack, waited out before the final verdict
    localparam int    TAIL_CYCLES = 40;

    typedef struct {
        ppl_pkg::t_func              func;
        ppl_pkg::t_idx               position;
        ppl_pkg::t_idx               remove_count;
        logic [ppl_pkg::DATA_W-1:0]  key;
        logic [ppl_pkg::DATA_W-1:0]  value;
    } t_list_op;

    typedef struct {
        ppl_pkg::t_status            status;
        logic                        removed_valid;
        logic [ppl_pkg::DATA_W-1:0]  key;
        logic [ppl_pkg::DATA_W-1:0]  value;
        logic                        last;
        ppl_pkg::t_idx               occupancy;
    } t_list_reply;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ppl_in_if  in_ch ();
    ppl_out_if out_ch ();

    positional_pair_list_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // operations waiting for the driver, replies waiting for the block
    t_list_op    pending_list_ops [$];
    t_list_reply awaited_replies [$];

    // shadow copy of the stored pairs and the fill count, advanced on every accepted item
    logic [ppl_pkg::DATA_W-1:0] shadow_keys [ppl_pkg::PPL_DEPTH];
    logic [ppl_pkg::DATA_W-1:0] shadow_values [ppl_pkg::PPL_DEPTH];
    int unsigned       shadow_fill = 0;

    // fill count as the stimulus generator expects it once all queued items are done
    int unsigned planned_fill = 0;

    int unsigned items_issued = 0;
    int unsigned items_accepted = 0;
    int unsigned replies_seen = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // shadow list: works out the replies of one accepted operation
    // ------------------------------------------------------------------
    task automatic apply_list_op(input t_list_op op);
        t_list_reply reply;
        int unsigned pos;
        int unsigned cnt;
        int unsigned i;
        bit          range_taken;
        pos = op.position;
        cnt = op.remove_count;
        range_taken = 1'b0;
        reply.status = ppl_pkg::STATUS_OK;
        reply.removed_valid = 1'b0;
        reply.key = '0;
        reply.value = '0;
        reply.last = 1'b1;
        case (op.func)
            ppl_pkg::FUNC_APPEND: begin
                if (shadow_fill >= ppl_pkg::PPL_DEPTH) begin
                    reply.status = ppl_pkg::STATUS_FULL;
                end else begin
                    shadow_keys[shadow_fill] = op.key;
                    shadow_values[shadow_fill] = op.value;
                    shadow_fill++;
                end
            end
            ppl_pkg::FUNC_INSERT: begin
                // the position check wins over the full check
                if (pos > shadow_fill) begin
                    reply.status = ppl_pkg::STATUS_BAD_POS;
                end else if (shadow_fill >= ppl_pkg::PPL_DEPTH) begin
                    reply.status = ppl_pkg::STATUS_FULL;
                end else begin
                    for (i = shadow_fill; i > pos; i--) begin
                        shadow_keys[i] = shadow_keys[i-1];
                        shadow_values[i] = shadow_values[i-1];
                    end
                    shadow_keys[pos] = op.key;
                    shadow_values[pos] = op.value;
                    shadow_fill++;
                end
            end
            ppl_pkg::FUNC_REMOVE: begin
                if (cnt == 0 || pos + cnt > shadow_fill) begin
                    reply.status = ppl_pkg::STATUS_BAD_RANGE;
                end else begin
                    // one reply per removed pair, all showing the fill count after removal
                    range_taken = 1'b1;
                    reply.removed_valid = 1'b1;
                    reply.occupancy = ppl_pkg::t_idx'(shadow_fill - cnt);
                    for (i = 0; i < cnt; i++) begin
                        reply.key = shadow_keys[pos+i];
                        reply.value = shadow_values[pos+i];
                        reply.last = (i + 1 == cnt);
                        awaited_replies = {awaited_replies, reply};
                    end
                    for (i = pos; i + cnt < shadow_fill; i++) begin
                        shadow_keys[i] = shadow_keys[i+cnt];
                        shadow_values[i] = shadow_values[i+cnt];
                    end
                    shadow_fill -= cnt;
                end
            end
            default: begin
            end
        endcase
        if (!range_taken) begin
            reply.occupancy = ppl_pkg::t_idx'(shadow_fill);
            awaited_replies = {awaited_replies, reply};
        end
    endtask

    task automatic report_mismatch(input string what);
        $display("mismatch at reply %0d: %s", replies_seen, what);
        mismatch_count++;
    endtask

    task automatic check_reply(input t_list_reply got);
        t_list_reply want;
        if (awaited_replies.size() == 0) begin
            report_mismatch($sformatf("reply with nothing awaited, status %0d occupancy %0d",
                                      got.status, got.occupancy));
        end else begin
            want = awaited_replies.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.removed_valid !== want.removed_valid)
                report_mismatch($sformatf("removed_valid %0b, want %0b",
                                          got.removed_valid, want.removed_valid));
            if (got.key !== want.key)
                report_mismatch($sformatf("key_out %h, want %h", got.key, want.key));
            if (got.value !== want.value)
                report_mismatch($sformatf("value_out %h, want %h", got.value, want.value));
            if (got.last !== want.last)
                report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
            if (got.occupancy !== want.occupancy)
                report_mismatch($sformatf("occupancy %0d, want %0d",
                                          got.occupancy, want.occupancy));
        end
        replies_seen++;
    endtask

    // ------------------------------------------------------------------
    // driver: presents the next queued operation, idling at random
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : driver
        t_list_op next_op;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (pending_list_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_op = pending_list_ops.pop_front();
                items_issued++;
                in_ch.valid        <= 1'b1;
                in_ch.func         <= next_op.func;
                in_ch.position     <= next_op.position;
                in_ch.remove_count <= next_op.remove_count;
                in_ch.key_in       <= next_op.key;
                in_ch.value_in     <= next_op.value;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // receiver side stalls at random
    always @(posedge i_clk) begin
        out_ch.ready <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // monitor: predicts on each accepted item, then checks each reply
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_list_op    seen_op;
        t_list_reply seen_reply;
        if (i_rst_n) begin
            // a reply in this edge never belongs to the item taken in it, so predict first
            if (in_ch.valid && in_ch.ready) begin
                seen_op.func = in_ch.func;
                seen_op.position = in_ch.position;
                seen_op.remove_count = in_ch.remove_count;
                seen_op.key = in_ch.key_in;
                seen_op.value = in_ch.value_in;
                apply_list_op(seen_op);
                items_accepted++;
            end
            if (out_ch.valid && out_ch.ready) begin
                seen_reply.status = out_ch.status;
                seen_reply.removed_valid = out_ch.removed_valid;
                seen_reply.key = out_ch.key_out;
                seen_reply.value = out_ch.value_out;
                seen_reply.last = out_ch.last;
                seen_reply.occupancy = out_ch.occupancy;
                check_reply(seen_reply);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // queues one operation and tracks the fill count it leaves behind
    task automatic queue_op(input ppl_pkg::t_func f, input int unsigned pos,
                            input int unsigned cnt,
                            input logic [ppl_pkg::DATA_W-1:0] k,
                            input logic [ppl_pkg::DATA_W-1:0] v);
        t_list_op op;
        op.func = f;
        op.position = ppl_pkg::t_idx'(pos);
        op.remove_count = ppl_pkg::t_idx'(cnt);
        op.key = k;
        op.value = v;
        pending_list_ops = {pending_list_ops, op};
        case (f)
            ppl_pkg::FUNC_APPEND:
                if (planned_fill < ppl_pkg::PPL_DEPTH) planned_fill++;
            ppl_pkg::FUNC_INSERT:
                if (pos <= planned_fill && planned_fill < ppl_pkg::PPL_DEPTH) planned_fill++;
            ppl_pkg::FUNC_REMOVE:
                if (cnt != 0 && pos + cnt <= planned_fill) planned_fill -= cnt;
            default: begin
            end
        endcase
    endtask

    // mostly well-formed operations on the current list, some noise
    task automatic queue_random_op();
        int unsigned pick;
        int unsigned cnt;
        int unsigned span;
        pick = $urandom_range(99);
        if (pick < 35) begin
            queue_op(ppl_pkg::FUNC_APPEND, $urandom_range(32), $urandom_range(32),
                     $urandom, $urandom);
        end else if (pick < 60) begin
            if (planned_fill < ppl_pkg::PPL_DEPTH && $urandom_range(9) != 0)
                queue_op(ppl_pkg::FUNC_INSERT, $urandom_range(planned_fill),
                         $urandom_range(32), $urandom, $urandom);
            else
                queue_op(ppl_pkg::FUNC_INSERT, $urandom_range(32), $urandom_range(32),
                         $urandom, $urandom);
        end else if (pick < 90) begin
            if (planned_fill > 0 && $urandom_range(6) != 0) begin
                span = (planned_fill < 6) ? planned_fill : 6;
                cnt = $urandom_range(span, 1);
                queue_op(ppl_pkg::FUNC_REMOVE, $urandom_range(planned_fill - cnt), cnt,
                         $urandom, $urandom);
            end else begin
                queue_op(ppl_pkg::FUNC_REMOVE, $urandom_range(32), $urandom_range(32),
                         $urandom, $urandom);
            end
        end else if (pick < 97) begin
            queue_op(ppl_pkg::t_func'($urandom_range(2)), $urandom_range(32),
                     $urandom_range(32), $urandom, $urandom);
        end else begin
            queue_op(FUNC_UNUSED, $urandom_range(32), $urandom_range(32), $urandom, $urandom);
        end
    endtask

    // fills the list to the top, knocks on the full list, then empties it
    task automatic fill_and_drain(input bit in_one_go);
        int unsigned cnt;
        int unsigned span;
        while (planned_fill < ppl_pkg::PPL_DEPTH) begin
            if ($urandom_range(1))
                queue_op(ppl_pkg::FUNC_APPEND, $urandom_range(32), $urandom_range(32),
                         $urandom, $urandom);
            else
                queue_op(ppl_pkg::FUNC_INSERT, $urandom_range(planned_fill),
                         $urandom_range(32), $urandom, $urandom);
        end
        queue_op(ppl_pkg::FUNC_APPEND, 0, 0, $urandom, $urandom);
        queue_op(ppl_pkg::FUNC_INSERT, ppl_pkg::PPL_DEPTH, 0, $urandom, $urandom);
        queue_op(ppl_pkg::FUNC_INSERT, 0, 0, $urandom, $urandom);
        queue_op(ppl_pkg::FUNC_INSERT, $urandom_range(ppl_pkg::PPL_DEPTH - 1, 1), 0,
                 $urandom, $urandom);
        queue_op(ppl_pkg::FUNC_REMOVE, ppl_pkg::PPL_DEPTH, 1, $urandom, $urandom);
        queue_op(ppl_pkg::FUNC_REMOVE, 1, ppl_pkg::PPL_DEPTH, $urandom, $urandom);
        if (in_one_go) begin
            queue_op(ppl_pkg::FUNC_REMOVE, 0, ppl_pkg::PPL_DEPTH, $urandom, $urandom);
        end else begin
            while (planned_fill > 0) begin
                span = (planned_fill < 8) ? planned_fill : 8;
                cnt = $urandom_range(span, 1);
                queue_op(ppl_pkg::FUNC_REMOVE, $urandom_range(planned_fill - cnt), cnt,
                         $urandom, $urandom);
            end
        end
    endtask

    // the sender holds back here until every awaited reply has come
    task automatic wait_until_drained();
        while (pending_list_ops.size() != 0 || items_accepted != items_issued ||
               awaited_replies.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin : stimulus
        int phase;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.func = ppl_pkg::FUNC_APPEND;
        in_ch.position = '0;
        in_ch.remove_count = '0;
        in_ch.key_in = '0;
        in_ch.value_in = '0;
        out_ch.ready = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part, starting from the empty list
        queue_op(ppl_pkg::FUNC_REMOVE, 0, 0, 32'h0, 32'h0);          // zero-length range
        queue_op(ppl_pkg::FUNC_REMOVE, 0, 1, 32'h0, 32'h0);          // range on empty list
        queue_op(ppl_pkg::FUNC_INSERT, 1, 0, 32'h1, 32'h1);          // insert past the end
        queue_op(FUNC_UNUSED, 5, 7, $urandom, $urandom);             // ignored code
        queue_op(ppl_pkg::FUNC_INSERT, 0, 0, 32'hFFFF_FFFF, 32'h0);  // insert into empty list
        queue_op(ppl_pkg::FUNC_APPEND, 0, 0, 32'h0, 32'hFFFF_FFFF);
        queue_op(ppl_pkg::FUNC_APPEND, 63, 63, $urandom, $urandom);
        queue_op(ppl_pkg::FUNC_INSERT, 3, 0, $urandom, $urandom);    // insert at the very end
        queue_op(ppl_pkg::FUNC_INSERT, 1, 0, $urandom, $urandom);    // insert in the middle
        queue_op(ppl_pkg::FUNC_INSERT, 6, 0, $urandom, $urandom);    // one past the end
        queue_op(ppl_pkg::FUNC_REMOVE, 1, 2, 32'h0, 32'h0);
        queue_op(ppl_pkg::FUNC_REMOVE, 2, 2, 32'h0, 32'h0);          // range runs past fill
        queue_op(ppl_pkg::FUNC_REMOVE, 0, 32, 32'h0, 32'h0);
        queue_op(ppl_pkg::FUNC_REMOVE, 32, 1, 32'h0, 32'h0);
        queue_op(ppl_pkg::FUNC_APPEND, 0, 0, $urandom, $urandom);
        queue_op(ppl_pkg::FUNC_REMOVE, 3, 1, 32'h0, 32'h0);          // last entry alone
        queue_op(ppl_pkg::FUNC_REMOVE, 0, 3, 32'h0, 32'h0);          // everything left
        queue_op(FUNC_UNUSED, 32, 32, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_op(ppl_pkg::FUNC_INSERT, 32, 32, $urandom, $urandom);  // far position, empty list
        wait_until_drained();

        // random part: free flow, slow sender, slow receiver, both slowed
        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            repeat (15) queue_random_op();
            fill_and_drain(phase[0]);
            repeat (10) queue_random_op();
            wait_until_drained();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && awaited_replies.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/ppl_pkg.sv
rtl/ppl_in_if.sv
rtl/ppl_out_if.sv
rtl/ppl_cell.sv
rtl/ppl_chain.sv
rtl/positional_pair_list_top.sv
verif/positional_pair_list_top_tb.sv
